### rtl/idq_pkg.sv
// Package for the integer divider: payload structs, status codes and
// the record that moves down the chain of divide cells. No dependencies.
package idq_pkg;

	localparam int unsigned DW      = 32;
	localparam int unsigned N_CELLS = DW;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_DIV0 = 2'd1,
		ST_OVF  = 2'd2
	} status_t;

	localparam logic [DW-1:0] SIGN_MIN = {1'b1, {(DW-1){1'b0}}};
	localparam logic [DW-1:0] ALL_ONES = {DW{1'b1}};

	typedef struct packed {
		logic          req_type;
		logic [DW-1:0] dividend;
		logic [DW-1:0] divisor;
	} req_t;

	typedef struct packed {
		logic [DW-1:0] quotient;
		logic [DW-1:0] remainder;
		logic [1:0]    status;
	} rsp_t;

	// Sign fix-up and status that ride alongside the division
	typedef struct packed {
		logic    neg_q;
		logic    neg_r;
		status_t status;
	} ctl_t;

	// Partial remainder, dividend/quotient shift word and divisor magnitude
	typedef struct packed {
		logic [DW-1:0] rem;
		logic [DW-1:0] dq;
		logic [DW-1:0] dvs;
		ctl_t          ctl;
	} stage_t;

endpackage

### rtl/idq_pre.sv
// Front stage of the divider: operand magnitudes, special cases, sign flags.
// Depends on idq_pkg.
module idq_pre (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  idq_pkg::req_t   in_data,
	output logic            nxt_valid,
	input  logic            nxt_ready,
	output idq_pkg::stage_t nxt_data
);
	import idq_pkg::*;

	logic   v_s1;
	stage_t d_s1;
	stage_t d_new;
	logic   sa, sb, zero, ovf;

	always_comb begin
		sa   = in_data.req_type & in_data.dividend[DW-1];
		sb   = in_data.req_type & in_data.divisor[DW-1];
		zero = (in_data.divisor == '0);
		ovf  = in_data.req_type && (in_data.dividend == SIGN_MIN)
			&& (in_data.divisor == ALL_ONES);
		// keep the raw dividend on divide by zero: the cells then yield
		// all-ones quotient and the dividend as remainder
		d_new.rem = '0;
		d_new.dq  = (sa && !zero) ? (DW'(0) - in_data.dividend) : in_data.dividend;
		d_new.dvs = sb ? (DW'(0) - in_data.divisor) : in_data.divisor;
		d_new.ctl.neg_q = !zero && (sa ^ sb);
		d_new.ctl.neg_r = !zero && sa;
		priority if (zero) begin
			d_new.ctl.status = ST_DIV0;
		end else if (ovf) begin
			d_new.ctl.status = ST_OVF;
		end else begin
			d_new.ctl.status = ST_OK;
		end
	end

	assign in_ready = !v_s1 || nxt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			d_s1 <= d_new;
		end
	end

	assign nxt_valid = v_s1;
	assign nxt_data  = d_s1;

endmodule

### rtl/idq_cell.sv
// One restoring-division cell: shift in one dividend bit, trial subtract,
// keep one quotient bit. Depends on idq_pkg.
module idq_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prv_valid,
	output logic            prv_ready,
	input  idq_pkg::stage_t prv_data,
	output logic            nxt_valid,
	input  logic            nxt_ready,
	output idq_pkg::stage_t nxt_data
);
	import idq_pkg::*;

	logic          v_q;
	stage_t        d_q;
	stage_t        d_new;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	always_comb begin
		trial = {prv_data.rem, prv_data.dq[DW-1]};
		diff  = trial - {1'b0, prv_data.dvs};
		ge    = !diff[DW];
		d_new       = prv_data;
		d_new.rem   = ge ? diff[DW-1:0] : trial[DW-1:0];
		d_new.dq    = {prv_data.dq[DW-2:0], ge};
	end

	// advance when empty or when the neighbor takes our transaction
	assign prv_ready = !v_q || nxt_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (prv_ready) begin
			v_q <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prv_ready && prv_valid) begin
			d_q <= d_new;
		end
	end

	assign nxt_valid = v_q;
	assign nxt_data  = d_q;

endmodule

### rtl/idq_post.sv
// Back stage of the divider: sign correction and the output register.
// Depends on idq_pkg.
module idq_post (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            prv_valid,
	output logic            prv_ready,
	input  idq_pkg::stage_t prv_data,
	output logic            out_valid,
	input  logic            out_ready,
	output idq_pkg::rsp_t   out_data
);
	import idq_pkg::*;

	logic v_q;
	rsp_t d_q;
	rsp_t d_new;

	always_comb begin
		d_new.quotient  = prv_data.ctl.neg_q ? (DW'(0) - prv_data.dq) : prv_data.dq;
		d_new.remainder = prv_data.ctl.neg_r ? (DW'(0) - prv_data.rem) : prv_data.rem;
		d_new.status    = prv_data.ctl.status;
	end

	assign prv_ready = !v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (prv_ready) begin
			v_q <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prv_ready && prv_valid) begin
			d_q <= d_new;
		end
	end

	assign out_valid = v_q;
	assign out_data  = d_q;

endmodule

### rtl/int_divide_quotient_remainder_top.sv
// Top level of the 32-bit signed/unsigned integer divider.
// Depends on idq_pkg, idq_pre, idq_cell and idq_post.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one division request
//   per transaction: req_type (0 unsigned, 1 signed), dividend, divisor.
//   Output channel (out_valid/out_ready/out_data) returns one transaction
//   per request, in order: quotient truncated toward zero, remainder with
//   the dividend's sign, and status (0 ok, 1 divide by zero, 2 overflow).
//   Divide by zero gives an all-ones quotient and the dividend as
//   remainder; signed minimum over minus one gives the minimum with a
//   zero remainder.
//   On the accepting edge the operand stage loads; the transaction then passes
//   through 32 restoring cells (one quotient bit each) and the output stage.
//   Throughput is one transaction per cycle while out_ready is high; each
//   stage is a register with its own valid bit, so up to 34 transactions are in flight.
//   When the receiver holds out_ready low, the output register holds its
//   transaction and bubbles ahead of it are squeezed out; in_ready drops
//   only when every stage is full.
//   Reset clears all valid bits; nothing else needs clearing.
module int_divide_quotient_remainder_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  idq_pkg::req_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output idq_pkg::rsp_t out_data
);
	import idq_pkg::*;

	// link i feeds cell i; link N_CELLS feeds the output stage
	logic   lnk_valid [N_CELLS+1];
	logic   lnk_ready [N_CELLS+1];
	stage_t lnk_data  [N_CELLS+1];

	idq_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.nxt_valid (lnk_valid[0]),
		.nxt_ready (lnk_ready[0]),
		.nxt_data  (lnk_data[0])
	);

	// one cell per quotient bit, most significant first
	for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
		idq_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prv_valid (lnk_valid[i]),
			.prv_ready (lnk_ready[i]),
			.prv_data  (lnk_data[i]),
			.nxt_valid (lnk_valid[i+1]),
			.nxt_ready (lnk_ready[i+1]),
			.nxt_data  (lnk_data[i+1])
		);
	end

	idq_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.prv_valid (lnk_valid[N_CELLS]),
		.prv_ready (lnk_ready[N_CELLS]),
		.prv_data  (lnk_data[N_CELLS]),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

`ifndef ASSERT_OFF
	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.status == ST_OK || out_data.status == ST_DIV0
			|| out_data.status == ST_OVF))
		else $error("illegal status code on output");

	a_div0_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_DIV0) |-> (out_data.quotient == ALL_ONES))
		else $error("divide by zero without all-ones quotient");

	a_ovf_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.status == ST_OVF)
			|-> (out_data.quotient == SIGN_MIN && out_data.remainder == '0))
		else $error("overflow result malformed");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled while output is free");
`endif

endmodule

### verif/tb.sv
// Self-checking testbench for int_divide_quotient_remainder_top.
// Depends on idq_pkg and the divider RTL: a directed table, then random
// signed/unsigned requests, checked against typed-in or predicted answers.
module tb;
	import idq_pkg::*;

	// Request type codes carried in req_t.req_type
	localparam logic REQ_UNSIGNED = 1'b0;
	localparam logic REQ_SIGNED   = 1'b1;

	localparam logic [DW-1:0] MAX_POS = ~SIGN_MIN;

	localparam int unsigned RANDOM_PER_PHASE = 376;
	localparam int unsigned CYCLE_LIMIT      = 200000;
	localparam int unsigned DRAIN_CYCLES     = 40;
	localparam int unsigned MAX_REPORTS      = 10;

	// One row of the directed table; typed_in marks a hand-written expectation
	typedef struct {
		req_t req;
		logic typed_in;
		rsp_t rsp;
	} div_case_t;

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic in_valid  = 1'b0;
	req_t in_data   = '0;
	logic out_ready = 1'b0;
	logic in_ready;
	logic out_valid;
	rsp_t out_data;

	// Handshake state sampled at the falling edge, where every signal is settled
	logic in_fire  = 1'b0;
	logic out_fire = 1'b0;
	rsp_t out_word = '0;

	rsp_t        pending_results[$];
	div_case_t   div_cases[$];
	int unsigned src_idle_pct  = 16;
	int unsigned sink_idle_pct = 48;
	int unsigned error_count   = 0;
	int unsigned cycle_count   = 0;

	int_divide_quotient_remainder_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 10-unit clock period
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Inputs only move at the rising edge, so the values seen here are the
	// ones the next rising edge will act on.
	always @(negedge clk) begin
		in_fire  = in_valid && in_ready;
		out_fire = out_valid && out_ready;
		out_word = out_data;
	end

	// Quotient truncated toward zero, remainder takes the dividend's sign;
	// divide by zero and signed min / -1 get their own fixed answers.
	function automatic rsp_t predict_division(req_t r);
		logic [DW-1:0] a;
		logic [DW-1:0] b;
		logic [DW-1:0] mag_a;
		logic [DW-1:0] mag_b;
		logic [DW-1:0] mag_q;
		logic [DW-1:0] mag_r;
		rsp_t          res;
		a = r.dividend;
		b = r.divisor;
		if (b == '0) begin
			res.quotient  = ALL_ONES;
			res.remainder = a;
			res.status    = ST_DIV0;
		end else if (r.req_type == REQ_UNSIGNED) begin
			res.quotient  = a / b;
			res.remainder = a % b;
			res.status    = ST_OK;
		end else if (a == SIGN_MIN && b == ALL_ONES) begin
			res.quotient  = SIGN_MIN;
			res.remainder = '0;
			res.status    = ST_OVF;
		end else begin
			mag_a = a[DW-1] ? -a : a;
			mag_b = b[DW-1] ? -b : b;
			mag_q = mag_a / mag_b;
			mag_r = mag_a % mag_b;
			res.quotient  = (a[DW-1] ^ b[DW-1]) ? -mag_q : mag_q;
			res.remainder = a[DW-1] ? -mag_r : mag_r;
			res.status    = ST_OK;
		end
		return res;
	endfunction

	// Mix of magnitudes and edge values so signs, zero and extremes show up often
	function automatic logic [DW-1:0] pick_operand();
		logic [DW-1:0] v;
		int unsigned   k;
		case ($urandom_range(5))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(15);
			end
			2: begin
				v = -DW'($urandom_range(16, 1));
			end
			3: begin
				k = $urandom_range(5);
				if (k == 0)
					v = '0;
				else if (k == 1)
					v = 1;
				else if (k == 2)
					v = ALL_ONES;
				else if (k == 3)
					v = SIGN_MIN;
				else if (k == 4)
					v = MAX_POS;
				else
					v = 2;
			end
			4: begin
				v = DW'(1) << $urandom_range(DW-1);
				if ($urandom_range(1))
					v = ~v;
			end
			default: begin
				v = DW'($urandom) >> $urandom_range(DW-1);
			end
		endcase
		return v;
	endfunction

	task automatic add_case(input logic kind, input logic [DW-1:0] a, input logic [DW-1:0] b,
			input logic typed_in, input logic [DW-1:0] q, input logic [DW-1:0] r,
			input status_t st);
		div_case_t c;
		c.req.req_type  = kind;
		c.req.dividend  = a;
		c.req.divisor   = b;
		c.typed_in      = typed_in;
		c.rsp.quotient  = q;
		c.rsp.remainder = r;
		c.rsp.status    = st;
		div_cases.push_back(c);
	endtask

	// Present one transaction after a random gap and hold it until accepted.
	// Valid stays high into the next call unless that call idles first.
	task automatic send_request(input req_t r, input logic typed_in, input rsp_t typed_rsp);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= r;
		do
			@(posedge clk);
		while (!in_fire);
		pending_results.push_back(typed_in ? typed_rsp : predict_division(r));
	endtask

	task automatic report_field(input string field, input logic [DW-1:0] want,
			input logic [DW-1:0] got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("[%0t] %s mismatch: expected %h, got %h", $realtime, field, want, got);
	endtask

	// Receiver: drop ready at random at the sink's idle rate
	always @(posedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= sink_idle_pct);
	end

	// Compare each delivered transaction with the oldest outstanding expectation
	always @(posedge clk) begin
		rsp_t want;
		if (out_fire) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("[%0t] unexpected result: q=%h r=%h status=%0d", $realtime,
						out_word.quotient, out_word.remainder, out_word.status);
			end else begin
				want = pending_results.pop_front();
				if (out_word.quotient !== want.quotient)
					report_field("quotient", want.quotient, out_word.quotient);
				if (out_word.remainder !== want.remainder)
					report_field("remainder", want.remainder, out_word.remainder);
				if (out_word.status !== want.status)
					report_field("status", DW'(want.status), DW'(out_word.status));
			end
		end
	end

	// Watchdog: end the run if it hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		req_t r;
		rsp_t none;
		none = '0;

		// Extremes and error codes carry typed-in answers; the rest go to the predictor
		add_case(REQ_UNSIGNED, '0,       '0,       1'b1, ALL_ONES,      '0,       ST_DIV0);
		add_case(REQ_SIGNED,   ALL_ONES, '0,       1'b1, ALL_ONES,      ALL_ONES, ST_DIV0);
		add_case(REQ_UNSIGNED, SIGN_MIN, '0,       1'b1, ALL_ONES,      SIGN_MIN, ST_DIV0);
		add_case(REQ_SIGNED,   SIGN_MIN, ALL_ONES, 1'b1, SIGN_MIN,      '0,       ST_OVF);
		add_case(REQ_UNSIGNED, SIGN_MIN, ALL_ONES, 1'b1, '0,            SIGN_MIN, ST_OK);
		add_case(REQ_UNSIGNED, ALL_ONES, ALL_ONES, 1'b1, 32'd1,         '0,       ST_OK);
		add_case(REQ_UNSIGNED, ALL_ONES, 32'd1,    1'b1, ALL_ONES,      '0,       ST_OK);
		add_case(REQ_SIGNED,   ALL_ONES, ALL_ONES, 1'b1, 32'd1,         '0,       ST_OK);
		add_case(REQ_SIGNED,   SIGN_MIN, 32'd1,    1'b1, SIGN_MIN,      '0,       ST_OK);
		add_case(REQ_SIGNED,   MAX_POS,  ALL_ONES, 1'b1, 32'h8000_0001, '0,       ST_OK);
		add_case(REQ_SIGNED,   SIGN_MIN, 32'd2,    1'b1, 32'hC000_0000, '0,       ST_OK);
		add_case(REQ_UNSIGNED, '0,       ALL_ONES, 1'b1, '0,            '0,       ST_OK);
		add_case(REQ_UNSIGNED, 32'd1,    ALL_ONES, 1'b1, '0,            32'd1,    ST_OK);
		add_case(REQ_SIGNED,   SIGN_MIN, SIGN_MIN, 1'b1, 32'd1,         '0,       ST_OK);
		add_case(REQ_SIGNED,   MAX_POS,  SIGN_MIN, 1'b1, '0,            MAX_POS,  ST_OK);
		add_case(REQ_UNSIGNED, MAX_POS,  SIGN_MIN, 1'b1, '0,            MAX_POS,  ST_OK);
		add_case(REQ_SIGNED,   32'd7,          -32'd2,        1'b0, '0, '0, ST_OK);
		add_case(REQ_SIGNED,   -32'd7,         32'd2,         1'b0, '0, '0, ST_OK);
		add_case(REQ_SIGNED,   -32'd7,         -32'd2,        1'b0, '0, '0, ST_OK);
		add_case(REQ_UNSIGNED, 32'd7,          32'd2,         1'b0, '0, '0, ST_OK);
		add_case(REQ_SIGNED,   SIGN_MIN,       32'd3,         1'b0, '0, '0, ST_OK);
		add_case(REQ_UNSIGNED, 32'hDEAD_BEEF,  32'h0000_1234, 1'b0, '0, '0, ST_OK);
		add_case(REQ_SIGNED,   32'h5A5A_5A5A,  32'hA5A5_A5A5, 1'b0, '0, '0, ST_OK);
		add_case(REQ_SIGNED,   '0,             SIGN_MIN,      1'b0, '0, '0, ST_OK);

		// Hold reset, then release it at a rising edge
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table under the first idle pattern
		foreach (div_cases[i])
			send_request(div_cases[i].req, div_cases[i].typed_in, div_cases[i].rsp);

		// Random phases: slow receiver, then slow sender, then full rate
		for (int phase = 0; phase < 3; phase++) begin
			if (phase == 1) begin
				src_idle_pct  = 48;
				sink_idle_pct = 16;
			end else if (phase == 2) begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				r.req_type = 1'($urandom_range(1));
				r.dividend = pick_operand();
				r.divisor  = pick_operand();
				// Force the signed overflow case now and then
				if (r.req_type == REQ_SIGNED && $urandom_range(99) < 3) begin
					r.dividend = SIGN_MIN;
					r.divisor  = ALL_ONES;
				end
				send_request(r, 1'b0, none);
			end
		end
		in_valid <= 1'b0;

		// Drain outstanding results, then watch a little longer for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
